@@ rtl/core/ott_pkg.sv @@
// shared types and constants for the ordered task table
package ott_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  localparam logic [3:0] ActAppend     = 4'd0;
  localparam logic [3:0] ActReadAt     = 4'd1;
  localparam logic [3:0] ActRemoveAt   = 4'd2;
  localparam logic [3:0] ActFindPrio   = 4'd3;
  localparam logic [3:0] ActFindId     = 4'd4;
  localparam logic [3:0] ActRemovePrio = 4'd5;
  localparam logic [3:0] ActRemoveId   = 4'd6;
  localparam logic [3:0] ActSetState   = 4'd7;
  localparam logic [3:0] ActSchedule   = 4'd8;
  localparam logic [3:0] ActPurge      = 4'd9;

  localparam logic [1:0] StQueued   = 2'd0;
  localparam logic [1:0] StRunning  = 2'd1;
  localparam logic [1:0] StBlocked  = 2'd2;
  localparam logic [1:0] StFinished = 2'd3;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatFull     = 2'd1;
  localparam logic [1:0] StatNotFound = 2'd2;

  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  prio;
    logic [1:0]  st;
  } entry_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_SHIFT = 7'b0000100,
    S_EMIT  = 7'b0001000,
    S_COUNT = 7'b0010000,
    S_PURGE = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

endpackage

@@ rtl/core/ordered_task_table_top.sv @@
// ordered task table: one table memory walked by a sequencer
// searches walk the table from entry 0; removals then shift each later entry down one
// place; purge walks the table twice (count, then compact and emit). one request at a
// time, set by the single read port of the table memory; a full output register stalls
// it.
// reset clears the entry count and sets capacity to 16; the memory is not cleared.
module ordered_task_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  action_i,
  input  logic [3:0]  position_i,
  input  logic [15:0] task_key_i,
  input  logic [7:0]  task_priority_i,
  input  logic [1:0]  new_state_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  found_position_o,
  output logic [15:0] entry_key_o,
  output logic [7:0]  entry_priority_o,
  output logic [1:0]  entry_state_o,
  output logic [4:0]  entry_count_o,
  output logic        last_o
);

  localparam int unsigned IW = ott_pkg::IdxW;
  localparam int unsigned CW = ott_pkg::CntW;

  ott_pkg::entry_t mem [ott_pkg::TableDepth];
  ott_pkg::entry_t rd_q;
  logic            we;
  logic [IW-1:0]   wa, ra;
  ott_pkg::entry_t wd;
  logic            re;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  ott_pkg::state_e st_q, st_d;
  logic [4:0]  cap_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [3:0]  act_q;
  logic [15:0] key_q;
  logic [7:0]  prio_q;
  logic [1:0]  nst_q;
  logic [CW-1:0] i_q, i_d, w_q, w_d;
  logic        rdv_q, rdv_d;   // rd_q holds entry i_q (entry i_q + 1 while shifting)
  logic        hit_q, hit_d;
  logic        rem_q, rem_d;   // removal position latched
  logic [CW-1:0] nf_q, nf_d;   // finished entries seen by the purge count pass

  // captured entry for single results (before shifting overwrites rd_q)
  ott_pkg::entry_t sav_q;

  logic        ov_q;
  logic [1:0]  os_q;
  logic [IW-1:0] op_q;
  ott_pkg::entry_t oe_q;
  logic        ol_q;
  logic [CW-1:0] oc_q;
  logic        emit;
  logic [1:0]  es;
  logic [IW-1:0] ep;
  ott_pkg::entry_t ee;
  logic        el;

  logic [CW-1:0] cap_eff;
  assign cap_eff = (cap_q > 5'(ott_pkg::TableDepth)) ? CW'(ott_pkg::TableDepth)
                                                     : CW'(cap_q);

  logic out_free;
  assign out_free = !ov_q || out_ready_i;
  assign in_ready_o = (st_q == ott_pkg::S_IDLE);

  logic match;
  always_comb begin
    match = 1'b0;
    unique case (act_q) inside
      ott_pkg::ActFindPrio, ott_pkg::ActRemovePrio: match = rd_q.prio == prio_q;
      ott_pkg::ActFindId, ott_pkg::ActRemoveId, ott_pkg::ActSetState:
        match = rd_q.key == key_q;
      ott_pkg::ActSchedule: begin
        if (key_q != 16'd0 && rd_q.key == key_q)
          match = rd_q.st == ott_pkg::StQueued || rd_q.st == ott_pkg::StBlocked;
        else
          match = rd_q.prio == prio_q &&
                  (rd_q.st == ott_pkg::StQueued || rd_q.st == ott_pkg::StBlocked);
      end
      default: match = 1'b0;
    endcase
  end

  ott_pkg::entry_t upd;
  always_comb begin
    upd = rd_q;
    if (act_q == ott_pkg::ActSchedule) upd.st = ott_pkg::StRunning;
    else upd.st = nst_q;
  end

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; i_d = i_q; w_d = w_q;
    rdv_d = 1'b0; hit_d = hit_q; rem_d = rem_q; nf_d = nf_q;
    we = 1'b0; wa = '0; wd = rd_q; re = 1'b0; ra = '0;
    emit = 1'b0; es = ott_pkg::StatNotFound; ep = '0; ee = '0; el = 1'b1;
    unique case (st_q)
      ott_pkg::S_IDLE: begin
        if (in_valid_i) begin
          i_d = '0; w_d = '0; hit_d = 1'b0; rem_d = 1'b0; nf_d = '0;
          unique case (action_i) inside
            ott_pkg::ActAppend: st_d = ott_pkg::S_DONE;
            ott_pkg::ActReadAt, ott_pkg::ActRemoveAt: begin
              i_d = CW'(position_i);
              re = 1'b1; ra = position_i[IW-1:0];
              st_d = ott_pkg::S_SCAN;
            end
            ott_pkg::ActPurge: st_d = ott_pkg::S_COUNT;
            default: st_d = ott_pkg::S_SCAN;
          endcase
        end
      end
      ott_pkg::S_SCAN: begin
        if (act_q == ott_pkg::ActReadAt || act_q == ott_pkg::ActRemoveAt) begin
          if (i_q >= cnt_q) st_d = ott_pkg::S_DONE;
          else if (rdv_q) begin
            hit_d = 1'b1; w_d = i_q;
            st_d = (act_q == ott_pkg::ActRemoveAt) ? ott_pkg::S_SHIFT
                                                    : ott_pkg::S_EMIT;
          end else rdv_d = 1'b1;
        end else if (act_q > ott_pkg::ActSchedule || act_q < ott_pkg::ActFindPrio
                     || i_q >= cnt_q) begin
          st_d = hit_q ? ott_pkg::S_EMIT : ott_pkg::S_DONE;
        end else if (!rdv_q) begin
          re = 1'b1; ra = i_q[IW-1:0]; rdv_d = 1'b1;
        end else if (match) begin
          if (act_q == ott_pkg::ActSetState) begin
            we = 1'b1; wa = i_q[IW-1:0]; wd = upd;
            if (!hit_q) begin w_d = i_q; hit_d = 1'b1; end
            i_d = i_q + 1'b1;
          end else if (act_q == ott_pkg::ActSchedule) begin
            we = 1'b1; wa = i_q[IW-1:0]; wd = upd;
            w_d = i_q; hit_d = 1'b1; st_d = ott_pkg::S_EMIT;
          end else begin
            w_d = i_q; hit_d = 1'b1;
            st_d = (act_q == ott_pkg::ActRemovePrio || act_q == ott_pkg::ActRemoveId)
                   ? ott_pkg::S_SHIFT : ott_pkg::S_EMIT;
          end
        end else i_d = i_q + 1'b1;
      end
      ott_pkg::S_SHIFT: begin
        // rd_q holds removed entry first; keep it in the output register path
        if (!rdv_q && !rem_q) begin
          rem_d = 1'b1; w_d = i_q;  // w_q: position of the removed entry
        end
        if (i_q + 1'b1 >= cnt_q) begin
          cnt_d = cnt_q - 1'b1;
          st_d = ott_pkg::S_EMIT;
        end else if (!rdv_q) begin
          re = 1'b1; ra = IW'(i_q + 1'b1); rdv_d = 1'b1;
        end else begin
          we = 1'b1; wa = i_q[IW-1:0]; wd = rd_q;
          i_d = i_q + 1'b1;
        end
      end
      ott_pkg::S_EMIT: begin
        if (out_free) begin
          emit = 1'b1; es = ott_pkg::StatOk; ep = w_q[IW-1:0]; ee = sav_q;
          st_d = ott_pkg::S_IDLE;
        end
      end
      ott_pkg::S_COUNT: begin
        // first pass: count finished entries so each result knows the final count
        if (i_q >= cnt_q) begin
          i_d = '0;
          st_d = (nf_q == '0) ? ott_pkg::S_DONE : ott_pkg::S_PURGE;
        end else if (!rdv_q) begin
          re = 1'b1; ra = i_q[IW-1:0]; rdv_d = 1'b1;
        end else begin
          if (rd_q.st == ott_pkg::StFinished) nf_d = nf_q + 1'b1;
          i_d = i_q + 1'b1;
        end
      end
      ott_pkg::S_PURGE: begin
        if (i_q >= cnt_q) begin
          cnt_d = w_q; st_d = ott_pkg::S_IDLE;
        end else if (!rdv_q) begin
          re = 1'b1; ra = i_q[IW-1:0]; rdv_d = 1'b1;
        end else if (rd_q.st == ott_pkg::StFinished) begin
          rdv_d = 1'b1;
          if (out_free) begin
            emit = 1'b1; es = ott_pkg::StatOk; ep = i_q[IW-1:0]; ee = rd_q;
            // i_q - w_q entries already emitted
            el = ((i_q - w_q) == (nf_q - 1'b1));
            i_d = i_q + 1'b1; rdv_d = 1'b0;
          end
        end else begin
          we = 1'b1; wa = w_q[IW-1:0]; wd = rd_q;
          w_d = w_q + 1'b1; i_d = i_q + 1'b1;
        end
      end
      ott_pkg::S_DONE: begin
        if (out_free) begin
          emit = 1'b1;
          if (act_q == ott_pkg::ActAppend) begin
            if (cnt_q < cap_eff) begin
              ee.key = key_q; ee.prio = prio_q; ee.st = nst_q;
              we = 1'b1; wa = cnt_q[IW-1:0]; wd = ee;
              es = ott_pkg::StatOk; ep = cnt_q[IW-1:0];
              cnt_d = cnt_q + 1'b1;
            end else es = ott_pkg::StatFull;
          end
          st_d = ott_pkg::S_IDLE;
        end
      end
      default: st_d = ott_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ott_pkg::S_SCAN && rdv_q) begin
      if (act_q == ott_pkg::ActSchedule || act_q == ott_pkg::ActSetState) begin
        if (match && !hit_q) sav_q <= upd;
      end else if (!hit_q) sav_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ott_pkg::S_IDLE;
      cap_q <= 5'd16;
      cnt_q <= '0;
      i_q <= '0; w_q <= '0; rdv_q <= 1'b0; hit_q <= 1'b0; rem_q <= 1'b0;
      nf_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; i_q <= i_d; w_q <= w_d;
      rdv_q <= rdv_d; hit_q <= hit_d; rem_q <= rem_d; nf_q <= nf_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ott_pkg::S_IDLE && in_valid_i) begin
      act_q <= action_i; key_q <= task_key_i;
      prio_q <= task_priority_i; nst_q <= new_state_i;
    end
    if (emit) begin
      os_q <= es; op_q <= ep; oe_q <= ee; ol_q <= el;
      // purge results carry the count after the whole purge
      oc_q <= (st_q == ott_pkg::S_PURGE) ? cnt_q - nf_q : cnt_d;
    end
  end

  assign out_valid_o      = ov_q;
  assign status_o         = os_q;
  assign found_position_o = 4'(op_q);
  assign entry_key_o      = oe_q.key;
  assign entry_priority_o = oe_q.prio;
  assign entry_state_o    = oe_q.st;
  assign entry_count_o    = 5'(oc_q);
  assign last_o           = ol_q;

endmodule

@@ bench/tb.sv @@
// self-checking testbench for the ordered task table
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  pos;
    logic [15:0] key;
    logic [7:0]  prio;
    logic [1:0]  st;
    logic [4:0]  cnt;
    logic        last;
  } task_result_t;

  typedef struct packed {
    logic [3:0]  act;
    logic [3:0]  pos;
    logic [15:0] key;
    logic [7:0]  prio;
    logic [1:0]  nst;
    logic        typed;
    logic [1:0]  exp_status;
    logic [4:0]  exp_cnt;
  } stim_row_t;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 60;
  localparam int NumDirected = 23;
  localparam int NumRandom = 390;
  localparam int MaxPurge = 16;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        in_valid, in_ready;
  logic [3:0]  action;
  logic [3:0]  position;
  logic [15:0] task_key;
  logic [7:0]  task_priority;
  logic [1:0]  new_state;
  logic        out_valid, out_ready;
  logic [1:0]  dut_status;
  logic [3:0]  dut_pos;
  logic [15:0] dut_key;
  logic [7:0]  dut_prio;
  logic [1:0]  dut_state;
  logic [4:0]  dut_cnt;
  logic        dut_last;
  task_result_t actual;

  assign actual = {dut_status, dut_pos, dut_key, dut_prio, dut_state, dut_cnt, dut_last};

  ordered_task_table_top i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .action_i         (action),
    .position_i       (position),
    .task_key_i       (task_key),
    .task_priority_i  (task_priority),
    .new_state_i      (new_state),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (dut_status),
    .found_position_o (dut_pos),
    .entry_key_o      (dut_key),
    .entry_priority_o (dut_prio),
    .entry_state_o    (dut_state),
    .entry_count_o    (dut_cnt),
    .last_o           (dut_last)
  );

  // shadow copy of the table
  logic [15:0] tbl_key [ott_pkg::TableDepth];
  logic [7:0]  tbl_prio [ott_pkg::TableDepth];
  logic [1:0]  tbl_st [ott_pkg::TableDepth];
  int unsigned tbl_count;
  int unsigned tbl_capacity;

  task_result_t expected_results [$];
  bit failed;
  bit idle_enabled;
  int cycles;

  stim_row_t dir_rows [NumDirected] = '{
    '{ott_pkg::ActReadAt, 4'd0, 16'h0000, 8'h00, ott_pkg::StQueued, 1'b1,
      ott_pkg::StatNotFound, 5'd0},
    '{ott_pkg::ActRemoveAt, 4'd15, 16'h0000, 8'h00, ott_pkg::StQueued, 1'b1,
      ott_pkg::StatNotFound, 5'd0},
    '{ott_pkg::ActPurge, 4'd0, 16'h0000, 8'h00, ott_pkg::StQueued, 1'b1,
      ott_pkg::StatNotFound, 5'd0},
    '{4'd15, 4'd0, 16'hffff, 8'hff, ott_pkg::StFinished, 1'b1,
      ott_pkg::StatNotFound, 5'd0},
    '{4'd10, 4'd5, 16'h0001, 8'h01, ott_pkg::StRunning, 1'b1,
      ott_pkg::StatNotFound, 5'd0},
    '{ott_pkg::ActFindPrio, 4'd0, 16'h0000, 8'h00, ott_pkg::StQueued, 1'b1,
      ott_pkg::StatNotFound, 5'd0},
    '{ott_pkg::ActAppend, 4'd0, 16'h0000, 8'h00, ott_pkg::StQueued, 1'b1,
      ott_pkg::StatOk, 5'd1},
    '{ott_pkg::ActAppend, 4'd15, 16'hffff, 8'hff, ott_pkg::StFinished, 1'b1,
      ott_pkg::StatOk, 5'd2},
    '{ott_pkg::ActAppend, 4'd0, 16'h1234, 8'h00, ott_pkg::StBlocked, 1'b1,
      ott_pkg::StatOk, 5'd3},
    '{ott_pkg::ActAppend, 4'd0, 16'h0005, 8'h07, ott_pkg::StRunning, 1'b1,
      ott_pkg::StatOk, 5'd4},
    '{ott_pkg::ActFindPrio, 4'd0, 16'h0000, 8'h00, ott_pkg::StQueued, 1'b0,
      ott_pkg::StatOk, 5'd0},
    '{ott_pkg::ActFindId, 4'd0, 16'hffff, 8'h00, ott_pkg::StQueued, 1'b0,
      ott_pkg::StatOk, 5'd0},
    // zero id matches by priority only
    '{ott_pkg::ActSchedule, 4'd0, 16'h0000, 8'h00, ott_pkg::StQueued, 1'b0,
      ott_pkg::StatOk, 5'd0},
    '{ott_pkg::ActSchedule, 4'd0, 16'h1234, 8'h63, ott_pkg::StQueued, 1'b0,
      ott_pkg::StatOk, 5'd0},
    // id hit on a running entry is skipped without a priority test
    '{ott_pkg::ActSchedule, 4'd0, 16'h0005, 8'h07, ott_pkg::StQueued, 1'b0,
      ott_pkg::StatOk, 5'd0},
    '{ott_pkg::ActSetState, 4'd0, 16'h1234, 8'h00, ott_pkg::StFinished, 1'b0,
      ott_pkg::StatOk, 5'd0},
    '{ott_pkg::ActSetState, 4'd0, 16'haaaa, 8'h00, ott_pkg::StQueued, 1'b1,
      ott_pkg::StatNotFound, 5'd4},
    '{ott_pkg::ActReadAt, 4'd3, 16'h0000, 8'h00, ott_pkg::StQueued, 1'b0,
      ott_pkg::StatOk, 5'd0},
    '{ott_pkg::ActReadAt, 4'd2, 16'h0000, 8'h00, ott_pkg::StQueued, 1'b0,
      ott_pkg::StatOk, 5'd0},
    '{ott_pkg::ActPurge, 4'd0, 16'h0000, 8'h00, ott_pkg::StQueued, 1'b0,
      ott_pkg::StatOk, 5'd0},
    '{ott_pkg::ActRemovePrio, 4'd0, 16'h0000, 8'h07, ott_pkg::StQueued, 1'b0,
      ott_pkg::StatOk, 5'd0},
    '{ott_pkg::ActRemoveId, 4'd0, 16'h0000, 8'h00, ott_pkg::StQueued, 1'b0,
      ott_pkg::StatOk, 5'd0},
    '{ott_pkg::ActRemoveId, 4'd0, 16'h9999, 8'h00, ott_pkg::StQueued, 1'b1,
      ott_pkg::StatNotFound, 5'd0}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout", $time);
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!idle_enabled) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 20);
  end

  // outputs are stable at the falling edge; a result seen here is taken at the next rise
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, actual);
        failed = 1'b1;
      end else begin
        if (actual !== expected_results[0]) begin
          $display("%0t: expected %p actual %p", $time, expected_results[0], actual);
          failed = 1'b1;
        end
        void'(expected_results.pop_front());
      end
    end
  end

  task automatic shift_down(input int unsigned p);
    for (int unsigned i = p; i + 1 < tbl_count; i++) begin
      tbl_key[i] = tbl_key[i+1];
      tbl_prio[i] = tbl_prio[i+1];
      tbl_st[i] = tbl_st[i+1];
    end
    tbl_count--;
  endtask

  task automatic predict_request(input logic [3:0] act, input logic [3:0] pos,
                                 input logic [15:0] key, input logic [7:0] prio,
                                 input logic [1:0] nst, output logic [1:0] first_status,
                                 output logic [4:0] first_cnt);
    task_result_t res [MaxPurge];
    int n;
    int unsigned cap, w;
    bit m, take, hit;
    n = 1;
    hit = 1'b0;
    w = 0;
    cap = (tbl_capacity > ott_pkg::TableDepth) ? ott_pkg::TableDepth : tbl_capacity;
    res[0] = '{ott_pkg::StatNotFound, 4'd0, 16'd0, 8'd0, 2'd0, 5'd0, 1'b0};
    case (act) inside
      ott_pkg::ActAppend: begin
        if (tbl_count < cap) begin
          tbl_key[tbl_count] = key;
          tbl_prio[tbl_count] = prio;
          tbl_st[tbl_count] = nst;
          res[0] = '{ott_pkg::StatOk, tbl_count[3:0], key, prio, nst, 5'd0, 1'b0};
          tbl_count++;
        end else res[0].status = ott_pkg::StatFull;
      end
      ott_pkg::ActReadAt, ott_pkg::ActRemoveAt: begin
        if (pos < tbl_count) begin
          res[0] = '{ott_pkg::StatOk, pos, tbl_key[pos], tbl_prio[pos], tbl_st[pos],
                     5'd0, 1'b0};
          if (act == ott_pkg::ActRemoveAt) shift_down(pos);
        end
      end
      ott_pkg::ActFindPrio, ott_pkg::ActFindId, ott_pkg::ActRemovePrio,
      ott_pkg::ActRemoveId: begin
        for (int unsigned i = 0; i < tbl_count; i++) begin
          m = (act == ott_pkg::ActFindPrio || act == ott_pkg::ActRemovePrio)
              ? (tbl_prio[i] == prio) : (tbl_key[i] == key);
          if (m) begin
            res[0] = '{ott_pkg::StatOk, i[3:0], tbl_key[i], tbl_prio[i], tbl_st[i],
                       5'd0, 1'b0};
            if (act == ott_pkg::ActRemovePrio || act == ott_pkg::ActRemoveId)
              shift_down(i);
            break;
          end
        end
      end
      ott_pkg::ActSetState: begin
        for (int unsigned i = 0; i < tbl_count; i++) begin
          if (tbl_key[i] == key) begin
            tbl_st[i] = nst;
            if (!hit) res[0] = '{ott_pkg::StatOk, i[3:0], key, tbl_prio[i], nst, 5'd0, 1'b0};
            hit = 1'b1;
          end
        end
      end
      ott_pkg::ActSchedule: begin
        for (int unsigned i = 0; i < tbl_count; i++) begin
          if (key != 16'd0 && tbl_key[i] == key)
            take = (tbl_st[i] == ott_pkg::StQueued || tbl_st[i] == ott_pkg::StBlocked);
          else
            take = tbl_prio[i] == prio &&
                   (tbl_st[i] == ott_pkg::StQueued || tbl_st[i] == ott_pkg::StBlocked);
          if (take) begin
            tbl_st[i] = ott_pkg::StRunning;
            res[0] = '{ott_pkg::StatOk, i[3:0], tbl_key[i], tbl_prio[i], ott_pkg::StRunning,
                       5'd0, 1'b0};
            break;
          end
        end
      end
      ott_pkg::ActPurge: begin
        n = 0;
        for (int unsigned i = 0; i < tbl_count; i++) begin
          if (tbl_st[i] == ott_pkg::StFinished && n < MaxPurge) begin
            res[n] = '{ott_pkg::StatOk, i[3:0], tbl_key[i], tbl_prio[i], ott_pkg::StFinished,
                       5'd0, 1'b0};
            n++;
          end else begin
            tbl_key[w] = tbl_key[i];
            tbl_prio[w] = tbl_prio[i];
            tbl_st[w] = tbl_st[i];
            w++;
          end
        end
        tbl_count = w;
        if (n == 0) n = 1;
      end
      default: ;
    endcase
    for (int k = 0; k < n; k++) begin
      res[k].cnt = tbl_count[4:0];
      res[k].last = (k == n - 1);
      expected_results.push_back(res[k]);
    end
    first_status = res[0].status;
    first_cnt = res[0].cnt;
  endtask

  // called at a rising edge; returns at the edge where the request is taken
  task automatic send_request(input stim_row_t row);
    logic [1:0] st;
    logic [4:0] cnt;
    while (idle_enabled && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= row.act;
    position <= row.pos;
    task_key <= row.key;
    task_priority <= row.prio;
    new_state <= row.nst;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_request(row.act, row.pos, row.key, row.prio, row.nst, st, cnt);
    if (row.typed && (st !== row.exp_status || cnt !== row.exp_cnt)) begin
      $display("%0t: expected status %0d count %0d actual status %0d count %0d",
               $time, row.exp_status, row.exp_cnt, st, cnt);
      failed = 1'b1;
    end
  endtask

  task automatic write_capacity(input logic [4:0] value);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tbl_capacity = value;
  endtask

  function automatic logic [15:0] pick_key();
    case ($urandom_range(5)) inside
      0: return 16'h0000;
      1: return 16'hffff;
      2, 3: return 16'($urandom_range(1, 4));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t r;
    int sel;
    r = '0;
    sel = $urandom_range(99);
    if (sel < 35) r.act = ott_pkg::ActAppend;
    else if (sel < 38) r.act = 4'($urandom_range(10, 15));
    else r.act = 4'($urandom_range(1, 9));
    r.pos = 4'($urandom_range(15));
    r.key = pick_key();
    r.prio = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    r.nst = 2'($urandom_range(3));
    return r;
  endfunction

  initial begin
    logic [4:0] caps [7] = '{5'd0, 5'd1, 5'd2, 5'd31, 5'd17, 5'd16, 5'd5};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    action = '0;
    position = '0;
    task_key = '0;
    task_priority = '0;
    new_state = '0;
    out_ready = 1'b0;
    cycles = 0;
    failed = 1'b0;
    idle_enabled = 1'b1;
    tbl_count = 0;
    tbl_capacity = 16;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_request(dir_rows[i]);

    // tiny capacities: an append at capacity 0 and the third append at capacity 2 must report a full table
    write_capacity(5'd0);
    send_request('{ott_pkg::ActAppend, 4'd0, 16'h0042, 8'h11, ott_pkg::StQueued, 1'b1,
                   ott_pkg::StatFull, 5'd0});
    write_capacity(5'd2);
    send_request('{ott_pkg::ActAppend, 4'd0, 16'h0042, 8'h11, ott_pkg::StQueued, 1'b1,
                   ott_pkg::StatOk, 5'd1});
    send_request('{ott_pkg::ActAppend, 4'd0, 16'h0043, 8'h12, ott_pkg::StFinished, 1'b1,
                   ott_pkg::StatOk, 5'd2});
    send_request('{ott_pkg::ActAppend, 4'd0, 16'h0044, 8'h13, ott_pkg::StQueued, 1'b1,
                   ott_pkg::StatFull, 5'd2});

    for (int i = 0; i < NumRandom; i++) begin
      if (i % 50 == 0)
        write_capacity((i / 50 < 7) ? caps[i / 50] : 5'($urandom_range(1, 16)));
      idle_enabled = !(i >= 150 && i < 240);
      send_request(random_row());
    end

    in_valid <= 1'b0;
    idle_enabled = 1'b1;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (!failed && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
